@@ hdl/ost_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered set table package
// Command codes and controller state encoding shared by the set table files.
// ----------------------------------------------------------------------------
package ost_pkg;

  // Width of one stored member.
  localparam int unsigned VALUE_W = 32;
  // Width of the reported member count.
  localparam int unsigned COUNT_W = 5;

  // Commands carried with each transaction.
  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SHIFT = 3'b100
  } state_t;

endpackage

@@ hdl/ost_mem.sv @@
// ----------------------------------------------------------------------------
// Ordered set table member store
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ost_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [ADDR_W-1:0]                   waddr,
  input  logic [ost_pkg::VALUE_W-1:0]         wdata,
  input  logic [ADDR_W-1:0]                   raddr,
  output logic [ost_pkg::VALUE_W-1:0]         rdata
);

  logic [ost_pkg::VALUE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ordered_set_table_unit.sv @@
// ----------------------------------------------------------------------------
// Ordered set table unit
// A fixed-capacity set of distinct signed 32-bit values held in insertion
// order with no gaps, stored in one synchronous memory.
//
//   Channel   Direction  Handshake          Payload
//   request   in         start / busy       command, value
//   result    out        done (one cycle)   ok, count
//
// A clear never raises busy. Add, contains and a remove that misses hold
// busy while the pipelined scan compares the used entries, read through the
// memory read port; a hit ends the scan early. A remove that hits then
// shifts the later entries down through the same read port. The result
// strobe appears the cycle after the work ends, when busy is already low,
// so a new transaction may be taken while it shows. Reset clears the
// member count; the memory contents need no clearing.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module ordered_set_table_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command,
  input  logic signed [ost_pkg::VALUE_W-1:0]  value,
  output logic                                done,
  output logic                                ok,
  output logic [ost_pkg::COUNT_W-1:0]         count
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  ost_pkg::state_t              state, state_next;
  ost_pkg::cmd_t                cmd;
  logic [ost_pkg::VALUE_W-1:0]  key;
  logic [CNT_W-1:0]             member_count, member_count_next;
  logic [CNT_W-1:0]             ptr, ptr_next;
  logic                         chk_valid, chk_valid_next;
  logic [CNT_W-1:0]             chk_pos, chk_pos_next;
  logic                         done_next;
  logic                         ok_next;
  logic [31:0]                  count_wide;
  logic                         accept;
  logic                         match;

  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  logic [ost_pkg::VALUE_W-1:0]  mem_wdata;
  logic [ost_pkg::VALUE_W-1:0]  mem_rdata;

  assign busy   = (state != ost_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign match  = chk_valid && (mem_rdata == key);

  // Member store.
  ost_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  // Controller: scan the used entries, then append or shift down.
  always_comb begin
    state_next        = state;
    member_count_next = member_count;
    ptr_next          = ptr;
    chk_valid_next    = 1'b0;
    chk_pos_next      = chk_pos;
    done_next         = 1'b0;
    ok_next           = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = member_count[IDX_W-1:0];
    mem_wdata         = key;

    case (state)
      ost_pkg::ST_IDLE: begin
        if (accept) begin
          if (ost_pkg::cmd_t'(command) == ost_pkg::CMD_CLEAR) begin
            member_count_next = '0;
            ok_next           = 1'b1;
            done_next         = 1'b1;
          end else begin
            state_next = ost_pkg::ST_SCAN;
            ptr_next   = '0;
          end
        end
      end

      ost_pkg::ST_SCAN: begin
        if (match) begin
          // The value is present at chk_pos.
          case (cmd)
            ost_pkg::CMD_REMOVE: begin
              state_next = ost_pkg::ST_SHIFT;
              ptr_next   = chk_pos + ONE_CNT;
            end
            ost_pkg::CMD_CONTAINS: begin
              ok_next    = 1'b1;
              done_next  = 1'b1;
              state_next = ost_pkg::ST_IDLE;
            end
            default: begin
              done_next  = 1'b1;
              state_next = ost_pkg::ST_IDLE;
            end
          endcase
        end else if (!chk_valid && (ptr >= member_count)) begin
          // Every used entry has been compared without a hit.
          done_next  = 1'b1;
          state_next = ost_pkg::ST_IDLE;
          if ((cmd == ost_pkg::CMD_ADD) && (member_count < CAP_CNT)) begin
            mem_we            = 1'b1;
            mem_waddr         = member_count[IDX_W-1:0];
            mem_wdata         = key;
            member_count_next = member_count + ONE_CNT;
            ok_next           = 1'b1;
          end
        end else if (ptr < member_count) begin
          // Issue the next read; its data is compared in the following cycle.
          chk_valid_next = 1'b1;
          chk_pos_next   = ptr;
          ptr_next       = ptr + ONE_CNT;
        end
      end

      ost_pkg::ST_SHIFT: begin
        // Write back the entry read last cycle one place lower.
        if (chk_valid) begin
          mem_we    = 1'b1;
          mem_waddr = chk_pos[IDX_W-1:0];
          mem_wdata = mem_rdata;
        end
        if (ptr < member_count) begin
          chk_valid_next = 1'b1;
          chk_pos_next   = ptr - ONE_CNT;
          ptr_next       = ptr + ONE_CNT;
        end else if (!chk_valid) begin
          member_count_next = member_count - ONE_CNT;
          ok_next           = 1'b1;
          done_next         = 1'b1;
          state_next        = ost_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ost_pkg::ST_IDLE;
      end
    endcase
  end

  assign count_wide = 32'(member_count_next);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ost_pkg::ST_IDLE;
      member_count <= '0;
      chk_valid    <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      member_count <= member_count_next;
      chk_valid    <= chk_valid_next;
      done         <= done_next;
    end
  end

  // Payload registers: transaction operands, scan pointers and result.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= ost_pkg::cmd_t'(command);
      key <= value;
    end
    ptr     <= ptr_next;
    chk_pos <= chk_pos_next;
    if (done_next) begin
      ok    <= ok_next;
      count <= count_wide[ost_pkg::COUNT_W-1:0];
    end
  end

endmodule

@@ tb/tb_ordered_set_table_unit.sv @@
// ----------------------------------------------------------------------------
// Ordered set table unit testbench
// Drives add, remove, contains and clear transactions into the set table.
// A behavioural copy of the set predicts the ok flag and the member count.
// Each strobed result is checked against the oldest prediction. A directed
// opening covers the value extremes, duplicates, a full set and an empty set.
// Random phases then work over small value pools so that hits are common.
// ----------------------------------------------------------------------------
module tb_ordered_set_table_unit;
  import ost_pkg::*;

  localparam int unsigned SET_CAPACITY = 16;
  localparam int unsigned POOL_SIZE    = 24;

  // One pending request; hold makes the sender wait until the table is quiet.
  typedef struct {
    cmd_t              cmd;
    logic [VALUE_W-1:0] val;
    bit                hold;
  } request_t;

  // One predicted result.
  typedef struct {
    logic               ok;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                command = CMD_ADD;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      done;
  logic                      ok;
  logic [COUNT_W-1:0]        count;

  request_t     request_q[$];
  outcome_t     outcome_q[$];
  request_t     in_flight;
  logic [VALUE_W-1:0] set_vals[SET_CAPACITY];
  int unsigned  set_size = 0;
  int unsigned  gap_left = 0;
  int unsigned  calm_left = 0;
  int unsigned  failures = 0;

  ordered_set_table_unit #(.CAPACITY(SET_CAPACITY)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .command (command),
    .value   (value),
    .done    (done),
    .ok      (ok),
    .count   (count)
  );

  always #2 clk = ~clk;

  // Apply one command to the behavioural set and return the predicted result.
  function automatic outcome_t apply_command(input cmd_t c, input logic [VALUE_W-1:0] v);
    outcome_t res;
    int       pos;
    pos = -1;
    res.ok = 1'b0;
    for (int i = 0; i < set_size; i++) begin
      if (pos < 0 && set_vals[i] == v) pos = i;
    end
    case (c)
      CMD_ADD: begin
        if (set_size < SET_CAPACITY && pos < 0) begin
          set_vals[set_size] = v;
          set_size++;
          res.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos >= 0) begin
          for (int i = pos; i + 1 < set_size; i++) set_vals[i] = set_vals[i + 1];
          set_size--;
          res.ok = 1'b1;
        end
      end
      CMD_CONTAINS: begin
        res.ok = (pos >= 0);
      end
      default: begin
        set_size = 0;
        res.ok = 1'b1;
      end
    endcase
    res.count = set_size[COUNT_W-1:0];
    return res;
  endfunction

  // Idle time before the next request: mostly none, some short, a few long,
  // with occasional stretches of back-to-back transactions.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_request(input cmd_t c, input logic [VALUE_W-1:0] v, input bit hold);
    request_t req;
    req.cmd = c;
    req.val = v;
    req.hold = hold;
    request_q.push_back(req);
  endtask

  // Request driver: a transaction is taken at an edge with start high and busy
  // low; the prediction is made at that same edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        outcome_q.push_back(apply_command(in_flight.cmd, in_flight.val));
        gap_left = pick_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].hold && outcome_q.size() > 0)) begin
          in_flight = request_q.pop_front();
          start   <= 1'b1;
          command <= in_flight.cmd;
          value   <= in_flight.val;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: outputs are stable mid-cycle, so they are sampled on the
  // falling edge of the cycle in which the strobe shows.
  always @(negedge clk) begin
    outcome_t want;
    if (!rst && done !== 1'b0) begin
      if (outcome_q.size() == 0) begin
        $error("result with none expected: ok=%0b count=%0d", ok, count);
        failures++;
      end else begin
        want = outcome_q.pop_front();
        if (ok !== want.ok) begin
          $error("ok mismatch: expected %0b, got %0b", want.ok, ok);
          failures++;
        end
        if (count !== want.count) begin
          $error("count mismatch: expected %0d, got %0d", want.count, count);
          failures++;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [VALUE_W-1:0] pool[POOL_SIZE];
    int unsigned        add_pct;
    int unsigned        r;
    cmd_t               c;
    logic [VALUE_W-1:0] v;

    // Directed opening: empty set, extremes, duplicates, first and middle
    // removal, a full set and a clear.
    queue_request(CMD_CONTAINS, 32'd5, 1'b0);
    queue_request(CMD_REMOVE, 32'd5, 1'b0);
    queue_request(CMD_CLEAR, 32'd0, 1'b0);
    queue_request(CMD_ADD, 32'h8000_0000, 1'b0);
    queue_request(CMD_ADD, 32'h7FFF_FFFF, 1'b0);
    queue_request(CMD_ADD, 32'h0000_0000, 1'b0);
    queue_request(CMD_ADD, 32'hFFFF_FFFF, 1'b0);
    queue_request(CMD_ADD, 32'h7FFF_FFFF, 1'b0);
    queue_request(CMD_CONTAINS, 32'hFFFF_FFFF, 1'b0);
    queue_request(CMD_CONTAINS, 32'h8000_0000, 1'b0);
    queue_request(CMD_REMOVE, 32'h0000_0000, 1'b0);
    queue_request(CMD_CONTAINS, 32'h0000_0000, 1'b0);
    queue_request(CMD_REMOVE, 32'h8000_0000, 1'b0);
    for (int i = 0; i < SET_CAPACITY - 2; i++) begin
      queue_request(CMD_ADD, 32'h0000_1000 + i, 1'b0);
    end
    queue_request(CMD_ADD, 32'h0000_2000, 1'b0);
    queue_request(CMD_CONTAINS, 32'h0000_100D, 1'b0);
    queue_request(CMD_REMOVE, 32'h7FFF_FFFF, 1'b0);
    queue_request(CMD_CLEAR, 32'hA5A5_A5A5, 1'b0);

    // Random phases over a fresh small pool each time; the first request of
    // every phase waits until all outstanding results have come back.
    for (int ph = 0; ph < 14; ph++) begin
      for (int k = 0; k < POOL_SIZE; k++) pool[k] = $urandom;
      add_pct = $urandom_range(15, 75);
      for (int k = 0; k < 102; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          c = CMD_CLEAR;
        end else begin
          r = $urandom_range(0, 99);
          if (r < add_pct) c = CMD_ADD;
          else if (r < add_pct + (100 - add_pct) * 2 / 3) c = CMD_REMOVE;
          else c = CMD_CONTAINS;
        end
        if ($urandom_range(0, 9) == 0) v = $urandom;
        else v = pool[$urandom_range(0, POOL_SIZE - 1)];
        queue_request(c, v, k == 0);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() > 0 || start || outcome_q.size() > 0) @(negedge clk);
    repeat (2 * SET_CAPACITY + 8) @(posedge clk);

    if (failures == 0) begin
      $display("tb_ordered_set_table_unit: clean");
    end else begin
      $display("tb_ordered_set_table_unit: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("tb_ordered_set_table_unit: errors");
    $finish;
  end

endmodule
